>>> rtl/core/uart8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart8_pkg: shared types and constants of the 8n1 transceiver
// Timer width, bit period limits, frame lengths and the status records passed
// between the receiver, the transmitter and the top level.
// ----------------------------------------------------------------------------
package uart8_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;

  typedef logic [TIMER_WIDTH-1:0] ticks_t;
  typedef logic [3:0]             bit_count_t;

  localparam longint TIMER_MAX       = (64'd1 << TIMER_WIDTH) - 64'd1;
  localparam longint BIT_TICKS_RESET = 5208;
  localparam longint MIN_BIT_TICKS   = 2;
  localparam ticks_t BIT_TICKS_INIT  =
    ticks_t'((BIT_TICKS_RESET > TIMER_MAX) ? TIMER_MAX : BIT_TICKS_RESET);
  localparam ticks_t TICKS_ONE       = ticks_t'(1);

  localparam bit_count_t RX_SAMPLES = 4'd9;
  localparam bit_count_t TX_BITS    = 4'd10;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_LOAD = 2'd1,
    ACT_TAKE = 2'd2
  } action_t;

  typedef struct packed {
    logic [7:0] data;
    logic       full;
  } rx_status_t;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_status_t;

  typedef struct packed {
    logic       tx_line;
    logic [7:0] rx_byte;
    logic       rx_ready;
    logic       tx_busy;
  } result_t;

endpackage

>>> rtl/core/uart8_rx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart8_rx: 8n1 receiver
// Detects a start edge, samples mid bit once per bit period and latches the
// data byte after the ninth sample. Status shows the state after this tick.
// ----------------------------------------------------------------------------
module uart8_rx (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                take,
  input  logic                line,
  input  uart8_pkg::ticks_t   bit_ticks,
  output uart8_pkg::rx_status_t status
);
  import uart8_pkg::*;

  logic       prev_level, prev_level_next;
  logic [8:0] shift, shift_next;
  bit_count_t count, count_next;
  ticks_t     timer, timer_next;
  logic [7:0] data, data_next;
  logic       full, full_next;

  always_comb begin
    prev_level_next = line;
    shift_next      = shift;
    count_next      = count;
    timer_next      = timer;
    data_next       = data;
    full_next       = take ? 1'b0 : full;
    if (count != '0) begin
      if (timer <= TICKS_ONE) begin
        timer_next = bit_ticks;
        shift_next = {line, shift[8:1]};
        if (count >= RX_SAMPLES) begin
          // ninth sample: start bit drops out at the bottom
          data_next  = shift_next[8:1];
          full_next  = 1'b1;
          count_next = '0;
        end else begin
          count_next = count + 4'd1;
        end
      end else begin
        timer_next = timer - TICKS_ONE;
      end
    end else if (prev_level && !line) begin
      count_next = 4'd1;
      shift_next = '0;
      timer_next = bit_ticks >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b1;
      shift      <= '0;
      count      <= '0;
      timer      <= '0;
      data       <= '0;
      full       <= 1'b0;
    end else if (step) begin
      prev_level <= prev_level_next;
      shift      <= shift_next;
      count      <= count_next;
      timer      <= timer_next;
      data       <= data_next;
      full       <= full_next;
    end
  end

  assign status.data = data_next;
  assign status.full = full_next;

endmodule

>>> rtl/core/uart8_tx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart8_tx: 8n1 transmitter
// Loads start, data and stop bits and shifts one bit out per bit period.
// Status shows the line level and busy flag after this tick.
// ----------------------------------------------------------------------------
module uart8_tx (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                load,
  input  logic [7:0]          data,
  input  uart8_pkg::ticks_t   bit_ticks,
  output uart8_pkg::tx_status_t status
);
  import uart8_pkg::*;

  logic [9:0] shift, shift_next;
  bit_count_t count, count_next;
  ticks_t     timer, timer_next;

  always_comb begin
    shift_next = shift;
    count_next = count;
    timer_next = timer;
    if (load) begin
      // a load while busy drops the frame in flight
      shift_next = {1'b1, data, 1'b0};
      count_next = 4'd1;
      timer_next = bit_ticks;
    end else if (count != '0) begin
      if (timer <= TICKS_ONE) begin
        timer_next = bit_ticks;
        shift_next = {1'b1, shift[9:1]};
        count_next = (count >= TX_BITS) ? '0 : count + 4'd1;
      end else begin
        timer_next = timer - TICKS_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= '1;
      count <= '0;
      timer <= '0;
    end else if (step) begin
      shift <= shift_next;
      count <= count_next;
      timer <= timer_next;
    end
  end

  assign status.line = shift_next[0];
  assign status.busy = (count_next != '0);

endmodule

>>> rtl/core/uart8_n1_transceiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_8n1_transceiver: tick driven 8n1 serial transceiver
// One input transaction is one clock tick of the serial timing; every tick
// gives one result carrying the line and status after that tick.
//
//   channel  handshake               payload
//   in       in_valid / in_ready     action, rx_line, tx_byte
//   out      out_valid / out_ready   tx_line, rx_byte, rx_ready, tx_busy
//   cfg      cfg_valid / cfg_ready   cfg_data (bit_ticks)
//
// one transaction per cycle while in_ready is high; a result is registered
// into the output register, or into the skid entry while the output stalls.
// receiver and transmitter each update in a single pass. a two entry output
// stage (output register plus skid) keeps in_ready a pure register, so input
// is taken while one result waits on a stalled output. rst is synchronous;
// bit_ticks comes out of reset at 5208, cfg_ready is always high.
// ----------------------------------------------------------------------------
module uart_8n1_transceiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic       rx_line,
  input  logic [7:0] tx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       tx_line,
  output logic [7:0] rx_byte,
  output logic       rx_ready,
  output logic       tx_busy,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [uart8_pkg::CFG_WIDTH-1:0] cfg_data
);
  import uart8_pkg::*;

  ticks_t      bit_ticks, bit_ticks_next;
  logic [32:0] cfg_wide;
  logic        push, pop;
  rx_status_t  rx_status;
  tx_status_t  tx_status;
  result_t     res_new, out_res, skid_res;
  logic        skid_valid;

  assign cfg_ready = 1'b1;
  assign cfg_wide  = 33'(cfg_data);

  // clamp written period into the timer range
  always_comb begin
    priority if (cfg_wide < 33'(MIN_BIT_TICKS)) begin
      bit_ticks_next = ticks_t'(MIN_BIT_TICKS);
    end else if (cfg_wide > 33'(TIMER_MAX)) begin
      bit_ticks_next = ticks_t'(TIMER_MAX);
    end else begin
      bit_ticks_next = ticks_t'(cfg_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks <= BIT_TICKS_INIT;
    end else if (cfg_valid && cfg_ready) begin
      bit_ticks <= bit_ticks_next;
    end
  end

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  uart8_rx u_rx (
    .clk       (clk),
    .rst       (rst),
    .step      (push),
    .take      (action == ACT_TAKE),
    .line      (rx_line),
    .bit_ticks (bit_ticks),
    .status    (rx_status)
  );

  uart8_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .step      (push),
    .load      (action == ACT_LOAD),
    .data      (tx_byte),
    .bit_ticks (bit_ticks),
    .status    (tx_status)
  );

  assign res_new.tx_line  = tx_status.line;
  assign res_new.rx_byte  = rx_status.data;
  assign res_new.rx_ready = rx_status.full;
  assign res_new.tx_busy  = tx_status.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_res  <= skid_res;
        skid_res <= res_new;
      end else begin
        out_res <= res_new;
      end
    end else if (push) begin
      skid_res <= res_new;
    end
  end

  assign tx_line  = out_res.tx_line;
  assign rx_byte  = out_res.rx_byte;
  assign rx_ready = out_res.rx_ready;
  assign tx_busy  = out_res.tx_busy;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output entry");

  a_idle_line_high: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.tx_busy) |-> out_res.tx_line)
    else $error("transmit line low while transmitter idle");

  a_period_floor: assert property (@(posedge clk) disable iff (rst)
    bit_ticks >= ticks_t'(MIN_BIT_TICKS))
    else $error("bit period below minimum");
`endif

endmodule
